@@ hdl/spd_pkg.sv @@
// Shared types and constants for the spectrum peak region detector.
// No dependencies; every other file but spd_checker imports this package.
package spd_pkg;

  localparam int COEF_BITS      = 16;
  localparam int FRAC_BITS      = 13;
  localparam int NUM_COEF       = 6;
  localparam int ACC_BITS       = 36;
  localparam int FIELD_BITS     = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 36;

  localparam logic [ACC_BITS-1:0]  ACC_MAX           = {ACC_BITS{1'b1}};
  localparam logic [COEF_BITS-1:0] COEF_CENTER_RESET = 16'd8192;

  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_CENTER  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_OFF5    = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD_SQ = 3'd6;

  typedef logic [NUM_COEF-1:0][COEF_BITS-1:0] coef_vec_t;

  // Centre tap at 1.0, all other taps zero
  localparam coef_vec_t COEF_RESET = coef_vec_t'(COEF_CENTER_RESET);

  // Per-slot pipeline control: slot occupied, slot yields a result, last sample of spectrum
  typedef struct packed {
    logic vld;
    logic res;
    logic last;
  } spd_ctl_t;

endpackage

@@ hdl/spd_front.sv @@
// Front stage: sample window, baseline, sample counter and symmetric pair sums.
// Depends on spd_pkg.
module spd_front #(
  parameter int HALF_WIDTH  = 5,
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           accept,
  input  logic [SAMPLE_BITS-1:0]         sample,
  input  logic                           last,
  output logic signed [SAMPLE_BITS+1:0]  pair [HALF_WIDTH+1],
  output spd_pkg::spd_ctl_t              ctl,
  output logic [INDEX_BITS-1:0]          center
);
  import spd_pkg::*;

  localparam int TAPS  = 2 * HALF_WIDTH + 1;
  localparam int PAIRW = SAMPLE_BITS + 2;
  localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

  logic [SAMPLE_BITS-1:0] window [TAPS];
  logic [SAMPLE_BITS-1:0] baseline;
  logic [INDEX_BITS-1:0]  count;

  logic [SAMPLE_BITS-1:0] window_next [TAPS];
  logic [SAMPLE_BITS-1:0] baseline_next;
  logic signed [PAIRW-1:0] pair_next [HALF_WIDTH+1];
  logic signed [PAIRW-1:0] base2;

  always_comb begin
    window_next[0] = sample;
    for (int i = 1; i < TAPS; i++) begin
      window_next[i] = window[i-1];
    end
    baseline_next = (count == '0) ? sample : baseline;
    base2 = $signed({1'b0, baseline_next, 1'b0});
    pair_next[0] = $signed({2'b00, window_next[HALF_WIDTH]}) - $signed({2'b00, baseline_next});
    for (int d = 1; d <= HALF_WIDTH; d++) begin
      pair_next[d] = $signed({2'b00, window_next[HALF_WIDTH-d]})
                   + $signed({2'b00, window_next[HALF_WIDTH+d]}) - base2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        window[i] <= '0;
      end
      baseline <= '0;
      count    <= '0;
    end else if (accept) begin
      window   <= window_next;
      baseline <= baseline_next;
      if (last) begin
        count <= '0;
      end else if (count != INDEX_MAX) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= '{vld:  accept,
               res:  accept && (count >= INDEX_BITS'(TAPS - 1)),
               last: accept && last};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pair   <= pair_next;
      center <= count - INDEX_BITS'(HALF_WIDTH);
    end
  end

endmodule

@@ hdl/spd_corr.sv @@
// Correlation pipeline: tap products, partial sums, total, magnitude and threshold test.
// Depends on spd_pkg.
module spd_corr #(
  parameter int HALF_WIDTH  = 5,
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic signed [SAMPLE_BITS+1:0]     pair [HALF_WIDTH+1],
  input  spd_pkg::spd_ctl_t                 ctl_in,
  input  logic [INDEX_BITS-1:0]             center_in,
  input  spd_pkg::coef_vec_t                coef,
  input  logic [spd_pkg::ACC_BITS-1:0]      threshold_sq,
  output spd_pkg::spd_ctl_t                 ctl_out,
  output logic [INDEX_BITS-1:0]             center_out,
  output logic                              peak
);
  import spd_pkg::*;

  localparam int PAIRW  = SAMPLE_BITS + 2;
  localparam int PW     = PAIRW + COEF_BITS;
  localparam int NG     = (HALF_WIDTH + 2) / 2;
  localparam int SUMW   = PW + 3;
  localparam int MAGW   = SUMW - FRAC_BITS;
  localparam int CMPW   = (MAGW > ACC_BITS) ? MAGW : ACC_BITS;
  localparam int STAGES = 4;

  logic signed [PW-1:0]   prod [HALF_WIDTH+1];
  logic signed [SUMW-1:0] part [NG];
  logic signed [SUMW-1:0] part_next [NG];
  logic signed [SUMW-1:0] total;
  logic signed [SUMW-1:0] total_next;
  logic [SUMW-1:0]        abs_sum;
  logic [CMPW-1:0]        mag_ext;
  logic [ACC_BITS-1:0]    mag_sat;

  spd_ctl_t              ctl_q    [STAGES];
  logic [INDEX_BITS-1:0] center_q [STAGES];

  for (genvar g = 0; g < NG; g++) begin : g_part
    if (2 * g + 1 <= HALF_WIDTH) begin : g_two
      assign part_next[g] = SUMW'(prod[2*g]) + SUMW'(prod[2*g+1]);
    end else begin : g_one
      assign part_next[g] = SUMW'(prod[2*g]);
    end
  end

  always_comb begin
    total_next = '0;
    for (int g = 0; g < NG; g++) begin
      total_next = total_next + part[g];
    end
    abs_sum = total[SUMW-1] ? SUMW'(-total) : SUMW'(total);
    mag_ext = CMPW'(abs_sum[SUMW-1:FRAC_BITS]);
    mag_sat = (mag_ext > CMPW'(ACC_MAX)) ? ACC_MAX : mag_ext[ACC_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int d = 0; d <= HALF_WIDTH; d++) begin
        prod[d] <= $signed(pair[d]) * $signed(coef[d]);
      end
      part  <= part_next;
      total <= total_next;
      peak  <= mag_sat > threshold_sq;
      center_q[0] <= center_in;
      for (int s = 1; s < STAGES; s++) begin
        center_q[s] <= center_q[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < STAGES; s++) begin
        ctl_q[s] <= '0;
      end
    end else if (en) begin
      ctl_q[0] <= ctl_in;
      for (int s = 1; s < STAGES; s++) begin
        ctl_q[s] <= ctl_q[s-1];
      end
    end
  end

  assign ctl_out    = ctl_q[STAGES-1];
  assign center_out = center_q[STAGES-1];

endmodule

@@ hdl/spd_region.sv @@
// Peak run tracking and the result register.
// Depends on spd_pkg.
module spd_region #(
  parameter int INDEX_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  spd_pkg::spd_ctl_t                 ctl,
  input  logic [INDEX_BITS-1:0]             center,
  input  logic                              peak,
  output logic                              out_valid,
  output logic [spd_pkg::FIELD_BITS-1:0]    center_index,
  output logic                              is_peak,
  output logic                              region_done,
  output logic [spd_pkg::FIELD_BITS-1:0]    region_start,
  output logic [spd_pkg::FIELD_BITS-1:0]    region_end,
  output logic [spd_pkg::FIELD_BITS-1:0]    region_width
);
  import spd_pkg::*;

  logic                  in_region;
  logic [INDEX_BITS-1:0] open_start;
  logic [INDEX_BITS-1:0] end_next;
  logic                  done_next;

  assign done_next = !peak && in_region;
  assign end_next  = center - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_region  <= 1'b0;
      open_start <= '0;
      out_valid  <= 1'b0;
    end else if (en) begin
      out_valid <= ctl.vld && ctl.res;
      if (ctl.vld && ctl.last) begin
        in_region  <= 1'b0;
        open_start <= '0;
      end else if (ctl.vld && ctl.res) begin
        if (peak && !in_region) begin
          in_region  <= 1'b1;
          open_start <= center;
        end else if (done_next) begin
          in_region  <= 1'b0;
          open_start <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      center_index <= FIELD_BITS'(center);
      is_peak      <= peak;
      region_done  <= done_next;
      region_start <= done_next ? FIELD_BITS'(open_start) : '0;
      region_end   <= done_next ? FIELD_BITS'(end_next) : '0;
      region_width <= done_next ? FIELD_BITS'(INDEX_BITS'(end_next - open_start)) : '0;
    end
  end

endmodule

@@ hdl/spectrum_peak_region_detector.sv @@
// Spectrum peak region detector top level: configuration registers and pipeline.
// Depends on spd_pkg, spd_front, spd_corr and spd_region.
//
// Usage: samples enter on the s_ stream, one transaction per sample; s_tlast marks
// the final sample of a spectrum and the next sample starts a new one, its first
// sample serving as baseline. Each window centre gives one result transaction on
// the m_ stream once 2*HALF_WIDTH+1 samples of the spectrum have arrived: centre
// index, peak flag and, when a peak run has just ended, its start, end and width.
// A run still open at the end of a spectrum is dropped.
// Coefficients and the squared threshold are written through cfg_we/cfg_index/
// cfg_data while the stream is idle.
// Pipeline: a result passes through the front register, written at its sample's
// transaction, then the product, partial sum, total, threshold test and result
// registers.
// Throughput: one sample per cycle; the six pipeline registers advance together.
// When the receiver stalls with a result pending, the whole pipeline holds and
// s_tready drops in the same cycle. Reset clears the window, counter, region state
// and pipeline valids and restores the default coefficients (centre tap 1.0).
module spectrum_peak_region_detector #(
  parameter int HALF_WIDTH  = 5,
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [15:0]                           s_tdata,   // sample[15:0]
  input  logic                                  s_tlast,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [63:0]                           m_tdata,   // center_index, region_start,
                                                           // region_end, region_width
  output logic [1:0]                            m_tuser,   // is_peak, region_done
  input  logic                                  cfg_we,
  input  logic [spd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [spd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import spd_pkg::*;

  coef_vec_t           coef;
  logic [ACC_BITS-1:0] threshold_sq;

  logic en;
  logic accept;

  logic signed [SAMPLE_BITS+1:0] pair [HALF_WIDTH+1];
  spd_ctl_t              front_ctl;
  spd_ctl_t              corr_ctl;
  logic [INDEX_BITS-1:0] front_center;
  logic [INDEX_BITS-1:0] corr_center;
  logic                  peak;

  logic [FIELD_BITS-1:0] center_index;
  logic [FIELD_BITS-1:0] region_start;
  logic [FIELD_BITS-1:0] region_end;
  logic [FIELD_BITS-1:0] region_width;
  logic                  is_peak;
  logic                  region_done;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef         <= COEF_RESET;
      threshold_sq <= '0;
    end else if (cfg_we) begin
      if (cfg_index <= REG_COEF_OFF5) begin
        coef[cfg_index] <= cfg_data[COEF_BITS-1:0];
      end else if (cfg_index == REG_THRESHOLD_SQ) begin
        threshold_sq <= cfg_data[ACC_BITS-1:0];
      end
    end
  end

  spd_front #(
    .HALF_WIDTH (HALF_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .accept(accept),
    .sample(SAMPLE_BITS'(s_tdata)),
    .last  (s_tlast),
    .pair  (pair),
    .ctl   (front_ctl),
    .center(front_center)
  );

  spd_corr #(
    .HALF_WIDTH (HALF_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_corr (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .pair        (pair),
    .ctl_in      (front_ctl),
    .center_in   (front_center),
    .coef        (coef),
    .threshold_sq(threshold_sq),
    .ctl_out     (corr_ctl),
    .center_out  (corr_center),
    .peak        (peak)
  );

  spd_region #(
    .INDEX_BITS(INDEX_BITS)
  ) u_region (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .ctl         (corr_ctl),
    .center      (corr_center),
    .peak        (peak),
    .out_valid   (m_tvalid),
    .center_index(center_index),
    .is_peak     (is_peak),
    .region_done (region_done),
    .region_start(region_start),
    .region_end  (region_end),
    .region_width(region_width)
  );

  assign m_tdata = {region_width, region_end, region_start, center_index};
  assign m_tuser = {region_done, is_peak};

endmodule

@@ hdl/spd_checker.sv @@
// Port-level checker for the spectrum peak region detector, bound to the top level.
// Depends on spectrum_peak_region_detector.
module spd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [1:0]  m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not track output slot");

  a_done_not_peak: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0])
    else $error("region closed on a peak centre");

  a_width: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata[63:48] == 16'(m_tdata[47:32] - m_tdata[31:16]))
    else $error("region width mismatch");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata[63:16] == 48'd0)
    else $error("region fields set without a closed region");

endmodule

bind spectrum_peak_region_detector spd_checker u_spd_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

@@ sim/tb_spectrum_peak_region_detector.sv @@
// Self-checking testbench for spectrum_peak_region_detector: streams spectra through the
// s_ port, predicts every window result and checks the m_ stream against it.
// Depends on spd_pkg and the detector RTL.
module tb_spectrum_peak_region_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import spd_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } sample_item_t;

  typedef struct packed {
    logic [15:0] centre;
    logic        peak;
    logic        done;
    logic [15:0] rstart;
    logic [15:0] rend;
    logic [15:0] rspan;
  } window_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  spectrum_peak_region_detector i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  sample_item_t   pending_samples[$];
  window_result_t expected_windows[$];
  sample_item_t   next_item;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int samples_taken = 0;
  int err_count = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;

  // detector copy: configuration, window and region state
  logic signed [15:0] coef_q[NUM_COEF];
  logic [ACC_BITS-1:0] thr_q;
  logic [15:0] win_q[11];
  logic [15:0] baseline_q;
  logic [15:0] count_q;
  logic        region_open_q;
  logic [15:0] region_from_q;
  logic [15:0] kern[NUM_COEF];

  task automatic predict_window(input logic [15:0] s, input logic last);
    longint acc;
    logic [63:0] mag;
    logic peak;
    window_result_t r;
    for (int i = 10; i > 0; i--) win_q[i] = win_q[i-1];
    win_q[0] = s;
    if (count_q == 16'd0) baseline_q = s;
    if (count_q >= 16'd10) begin
      acc = longint'(coef_q[0]) * (longint'(win_q[5]) - longint'(baseline_q));
      for (int d = 1; d <= 5; d++) begin
        acc += longint'(coef_q[d]) * ((longint'(win_q[5-d]) - longint'(baseline_q)) +
                                      (longint'(win_q[5+d]) - longint'(baseline_q)));
      end
      mag = (acc < 0) ? 64'(-acc) : 64'(acc);
      mag = mag >> FRAC_BITS;
      if (mag > 64'(ACC_MAX)) mag = 64'(ACC_MAX);
      peak = mag > 64'(thr_q);
      r = '0;
      r.centre = count_q - 16'd5;
      r.peak = peak;
      if (peak) begin
        if (!region_open_q) begin
          region_open_q = 1'b1;
          region_from_q = r.centre;
        end
      end else if (region_open_q) begin
        r.done = 1'b1;
        r.rstart = region_from_q;
        r.rend = r.centre - 16'd1;
        r.rspan = r.rend - r.rstart;
        region_open_q = 1'b0;
        region_from_q = '0;
      end
      expected_windows.push_back(r);
    end
    if (last) begin
      count_q = '0;
      region_open_q = 1'b0;
      region_from_q = '0;
    end else if (count_q != 16'hFFFF) begin
      count_q++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_window(s_tdata, s_tlast);
        samples_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_samples.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= next_item.sample;
          s_tlast <= next_item.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      err_count++;
      if (err_count <= 40)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    window_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_windows.size() == 0) begin
          err_count++;
          if (err_count <= 40)
            $display("%0t: unexpected result: expected none, actual center %0d", $time,
                     m_tdata[15:0]);
        end else begin
          want = expected_windows.pop_front();
          check_field("center_index", want.centre, m_tdata[15:0]);
          check_field("is_peak", want.peak, m_tuser[0]);
          check_field("region_done", want.done, m_tuser[1]);
          check_field("region_start", want.rstart, m_tdata[31:16]);
          check_field("region_end", want.rend, m_tdata[47:32]);
          check_field("region_width", want.rspan, m_tdata[63:48]);
        end
      end
      if (!long_hold_done && samples_taken >= 200 && pending_samples.size() > 40) begin
        hold_left = 150;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx <= REG_COEF_OFF5) coef_q[idx] = val[COEF_BITS-1:0];
    else if (idx == REG_THRESHOLD_SQ) thr_q = val[ACC_BITS-1:0];
  endtask

  task automatic write_config(input logic [ACC_BITS-1:0] thr);
    for (int t = 0; t < NUM_COEF; t++) begin
      write_reg(CFG_INDEX_BITS'(REG_COEF_CENTER + t),
                {20'($urandom_range(0, 1048575)), kern[t]});
    end
    write_reg(REG_THRESHOLD_SQ, thr);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || s_tvalid || expected_windows.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic push_sample(input int v, input logic last);
    sample_item_t it;
    it.sample = 16'(v);
    it.last = last;
    pending_samples.push_back(it);
  endtask

  task automatic queue_spectrum(input int len, input bit noisy);
    int level, spread, bumps, at, height, w, idx;
    int vals[];
    vals = new[len];
    level = $urandom_range(0, 40000);
    spread = $urandom_range(0, 63);
    for (int i = 0; i < len; i++)
      vals[i] = noisy ? $urandom_range(0, 65535) : level + $urandom_range(0, spread);
    bumps = noisy ? 0 : len / 20 + $urandom_range(0, 3);
    for (int j = 0; j < bumps; j++) begin
      at = $urandom_range(0, len - 1);
      height = $urandom_range(500, 20000);
      w = $urandom_range(0, 4);
      for (int o = -w; o <= w; o++) begin
        idx = at + o;
        if (idx >= 0 && idx < len)
          vals[idx] += height * (w + 1 - (o < 0 ? -o : o)) / (w + 1);
      end
    end
    @(negedge clk);
    for (int i = 0; i < len; i++)
      push_sample(vals[i] > 65535 ? 65535 : vals[i], i == len - 1);
  endtask

  initial begin
    int queued, kind, len;
    int d1[14] = '{0, 65535, 0, 65535, 0, 65535, 0, 65535, 65535, 0, 65535, 0, 65535, 0};
    int d2[11] = '{65535, 65535, 0, 65535, 0, 0, 65535, 0, 65535, 0, 65535};
    for (int t = 0; t < NUM_COEF; t++) coef_q[t] = '0;
    coef_q[0] = COEF_CENTER_RESET;
    thr_q = '0;
    for (int i = 0; i < 11; i++) win_q[i] = '0;
    baseline_q = '0;
    count_q = '0;
    region_open_q = 1'b0;
    region_from_q = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: extremes, region close, region dropped at end, short spectrum
    send_idle_pct = 37;
    recv_idle_pct = 84;
    @(negedge clk);
    foreach (d1[i]) push_sample(d1[i], i == 13);
    foreach (d2[i]) push_sample(d2[i], i == 10);
    push_sample(12345, 1'b1);
    wait_drained();
    write_reg(REG_UNUSED, {CFG_DATA_BITS{1'b1}});
    @(posedge clk);
    cfg_we <= 1'b0;

    for (int p = 0; p < 12; p++) begin
      wait_drained();
      send_idle_pct = (p < 4) ? 37 : (p < 8) ? 84 : 0;
      recv_idle_pct = (p < 4) ? 84 : (p < 8) ? 37 : 0;
      kind = (p < 3) ? p : $urandom_range(2, 4);
      case (kind)
        0: begin
          foreach (kern[t]) kern[t] = 16'h8000;
          write_config('0);
        end
        1: begin
          foreach (kern[t]) kern[t] = 16'h7FFF;
          write_config(ACC_MAX);
        end
        2: begin
          foreach (kern[t]) kern[t] = '0;
          kern[0] = 16'($urandom_range(2048, 32767));
          write_config(ACC_BITS'($urandom_range(0, 6000)));
        end
        3: begin
          kern[0] = 16'($urandom_range(4096, 16383));
          for (int t = 1; t < NUM_COEF; t++)
            kern[t] = 16'(-$urandom_range(0, int'(kern[0]) / 10));
          write_config(ACC_BITS'($urandom_range(0, 6000)));
        end
        default: begin
          foreach (kern[t]) kern[t] = 16'($urandom);
          if ($urandom_range(9) == 0)
            write_config({4'($urandom_range(0, 15)), 32'($urandom)});
          else
            write_config(ACC_BITS'($urandom_range(0, 3000000)));
        end
      endcase
      queued = 0;
      while (queued < 130) begin
        case ($urandom_range(9))
          0: len = $urandom_range(1, 10);
          1: len = $urandom_range(11, 40);
          default: len = ($urandom_range(7) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(11, 48);
        endcase
        queue_spectrum(len, $urandom_range(9) == 1);
        queued += len;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
hdl/spd_pkg.sv
hdl/spd_front.sv
hdl/spd_corr.sv
hdl/spd_region.sv
hdl/spectrum_peak_region_detector.sv
hdl/spd_checker.sv
sim/tb_spectrum_peak_region_detector.sv
